### design/pfl_pkg.sv
// ----------------------------------------------------------------------------
// pfl_pkg
// Shared types and constants for the Phong fragment lighting pipeline.
// ----------------------------------------------------------------------------
package pfl_pkg;

   localparam int SqrtSteps = 31;
   localparam int DivSteps  = 16;
   localparam int PowSteps  = 8;

   typedef enum logic [2:0] {
      CSR_LIGHT_X  = 3'd0,
      CSR_LIGHT_Y  = 3'd1,
      CSR_LIGHT_Z  = 3'd2,
      CSR_AMBIENT  = 3'd3,
      CSR_DIFFUSE  = 3'd4,
      CSR_SPECULAR = 3'd5,
      CSR_SHINE    = 3'd6
   } csr_idx_type;

   // Unit vector in Q1.15, magnitude up to 32768, plus a nonzero-length flag.
   typedef struct packed {
      logic               ok;
      logic signed [16:0] x;
      logic signed [16:0] y;
      logic signed [16:0] z;
   } unit_type;

   typedef struct packed {
      logic [47:0] ambient;
      logic [47:0] diffuse;
      logic [47:0] specular;
      logic [7:0]  shine;
   } shade_cfg_type;

   typedef struct packed {
      logic [15:0] red;
      logic [15:0] green;
      logic [15:0] blue;
   } rgb_type;

endpackage

### design/pfl_if.sv
// ----------------------------------------------------------------------------
// pfl_req_if / pfl_rsp_if
// Valid/ready channels carrying a normal word in and a color word out.
// ----------------------------------------------------------------------------
interface pfl_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] normal_x;
   logic signed [15:0] normal_y;
   logic signed [15:0] normal_z;

   modport source (output valid, output normal_x, output normal_y, output normal_z,
                   input ready);
   modport sink   (input valid, input normal_x, input normal_y, input normal_z,
                   output ready);
endinterface

interface pfl_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] red;
   logic [15:0] green;
   logic [15:0] blue;

   modport source (output valid, output red, output green, output blue, input ready);
   modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

### design/pfl_norm.sv
// ----------------------------------------------------------------------------
// pfl_norm
// Pipelined vector normalizer: squared length, bit-per-stage square root,
// then bit-per-stage division of each component by the length.
// ----------------------------------------------------------------------------
module pfl_norm (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  logic               in_valid,
   input  logic signed [15:0] in_x,
   input  logic signed [15:0] in_y,
   input  logic signed [15:0] in_z,
   output logic               out_valid,
   output pfl_pkg::unit_type  out_unit
);
   import pfl_pkg::*;

   typedef struct packed {
      logic            vld;
      logic            nz;
      logic [2:0]      sgn;
      logic [2:0][16:0] mag;
      logic [61:0]     rem;
      logic [30:0]     root;
   } sqs_type;

   typedef struct packed {
      logic            vld;
      logic            nz;
      logic [2:0]      sgn;
      logic [30:0]     len;
      logic [2:0][46:0] rem;
      logic [2:0][15:0] quo;
   } dvs_type;

   // Stage A: magnitudes and squares.
   logic             a_vld_ff;
   logic [2:0]       a_sgn_ff, a_sgn_in;
   logic [2:0][16:0] a_mag_ff, a_mag_in;
   logic [2:0][30:0] a_sq_ff, a_sq_in;
   logic [2:0][33:0] a_prod;
   logic signed [2:0][15:0] comp;

   assign comp = {in_x, in_y, in_z};

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         a_sgn_in[c] = comp[c][15];
         a_mag_in[c] = comp[c][15] ? 17'(-{comp[c][15], comp[c]}) : {1'b0, comp[c]};
         a_prod[c]   = a_mag_in[c] * a_mag_in[c];
         a_sq_in[c]  = a_prod[c][30:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else if (adv) begin
         a_vld_ff <= in_valid;
      end
      if (adv) begin
         a_sgn_ff <= a_sgn_in;
         a_mag_ff <= a_mag_in;
         a_sq_ff  <= a_sq_in;
      end
   end

   // Square root stages; entry 0 holds the squared length scaled by 2^30.
   sqs_type sq_ff [0:SqrtSteps];
   sqs_type sq_in [0:SqrtSteps];
   logic [31:0] len2;

   always_comb begin
      len2          = {1'b0, a_sq_ff[0]} + {1'b0, a_sq_ff[1]} + {1'b0, a_sq_ff[2]};
      sq_in[0].vld  = a_vld_ff;
      sq_in[0].nz   = (len2 != 32'd0);
      sq_in[0].sgn  = a_sgn_ff;
      sq_in[0].mag  = a_mag_ff;
      sq_in[0].rem  = {len2, 30'd0};
      sq_in[0].root = '0;
   end

   for (genvar k = 0; k < SqrtSteps; k++) begin : g_sqrt
      localparam int Bit = SqrtSteps - 1 - k;
      logic [62:0] trial;
      always_comb begin
         sq_in[k+1] = sq_ff[k];
         // Root bits so far lie above Bit, so the OR is an add.
         trial = ({32'd0, sq_ff[k].root} << (Bit + 1)) | (63'd1 << (2 * Bit));
         if ({1'b0, sq_ff[k].rem} >= trial) begin
            sq_in[k+1].rem  = sq_ff[k].rem - trial[61:0];
            sq_in[k+1].root = sq_ff[k].root | (31'd1 << Bit);
         end
      end
   end

   for (genvar k = 0; k <= SqrtSteps; k++) begin : g_sqrt_reg
      always_ff @(posedge clock) begin
         if (reset) begin
            sq_ff[k].vld <= 1'b0;
         end else if (adv) begin
            sq_ff[k].vld <= sq_in[k].vld;
         end
         if (adv) begin
            sq_ff[k].nz   <= sq_in[k].nz;
            sq_ff[k].sgn  <= sq_in[k].sgn;
            sq_ff[k].mag  <= sq_in[k].mag;
            sq_ff[k].rem  <= sq_in[k].rem;
            sq_ff[k].root <= sq_in[k].root;
         end
      end
   end

   // Division stages: quotient bit per stage, three components side by side.
   dvs_type dv_ff [0:DivSteps];
   dvs_type dv_in [0:DivSteps];

   always_comb begin
      dv_in[0].vld = sq_ff[SqrtSteps].vld;
      dv_in[0].nz  = sq_ff[SqrtSteps].nz;
      dv_in[0].sgn = sq_ff[SqrtSteps].sgn;
      dv_in[0].len = sq_ff[SqrtSteps].root;
      for (int c = 0; c < 3; c++) begin
         dv_in[0].rem[c] = {sq_ff[SqrtSteps].mag[c], 30'd0};
         dv_in[0].quo[c] = '0;
      end
   end

   for (genvar k = 0; k < DivSteps; k++) begin : g_div
      localparam int Bit = DivSteps - 1 - k;
      logic [46:0] dvsr;
      always_comb begin
         dv_in[k+1] = dv_ff[k];
         dvsr = {16'd0, dv_ff[k].len} << Bit;
         for (int c = 0; c < 3; c++) begin
            if (dv_ff[k].rem[c] >= dvsr) begin
               dv_in[k+1].rem[c] = dv_ff[k].rem[c] - dvsr;
               dv_in[k+1].quo[c] = dv_ff[k].quo[c] | (16'd1 << Bit);
            end
         end
      end
   end

   for (genvar k = 0; k <= DivSteps; k++) begin : g_div_reg
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[k].vld <= 1'b0;
         end else if (adv) begin
            dv_ff[k].vld <= dv_in[k].vld;
         end
         if (adv) begin
            dv_ff[k].nz  <= dv_in[k].nz;
            dv_ff[k].sgn <= dv_in[k].sgn;
            dv_ff[k].len <= dv_in[k].len;
            dv_ff[k].rem <= dv_in[k].rem;
            dv_ff[k].quo <= dv_in[k].quo;
         end
      end
   end

   logic signed [2:0][16:0] unit;

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         unit[c] = dv_ff[DivSteps].sgn[c] ? 17'(-{1'b0, dv_ff[DivSteps].quo[c]})
                                          : {1'b0, dv_ff[DivSteps].quo[c]};
      end
   end

   assign out_valid   = dv_ff[DivSteps].vld;
   assign out_unit.ok = dv_ff[DivSteps].nz;
   assign out_unit.x  = unit[2];
   assign out_unit.y  = unit[1];
   assign out_unit.z  = unit[0];

endmodule

### design/pfl_shade.sv
// ----------------------------------------------------------------------------
// pfl_shade
// Lighting pipeline: dot product, Lambert term, reflection z, shininess
// power by square-and-multiply, then per-channel accumulate and saturate.
// ----------------------------------------------------------------------------
module pfl_shade (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  logic                  in_valid,
   input  pfl_pkg::unit_type     light,
   input  pfl_pkg::unit_type     norm,
   input  pfl_pkg::shade_cfg_type cfg,
   output logic                  out_valid,
   output pfl_pkg::rgb_type      out_rgb
);
   import pfl_pkg::*;

   function automatic logic [15:0] qmul(input logic [15:0] a, input logic [15:0] b);
      logic [31:0] p;
      p = a * b + 32'd16384;
      return p[30:15];
   endfunction

   // Stage 1: component products.
   logic                    p1_vld_ff;
   logic                    p1_ok_ff;
   logic signed [2:0][33:0] p1_prod_ff, p1_prod_in;
   logic signed [16:0]      p1_nz_ff, p1_sz_ff;

   always_comb begin
      p1_prod_in[0] = light.x * norm.x;
      p1_prod_in[1] = light.y * norm.y;
      p1_prod_in[2] = light.z * norm.z;
   end

   // Stage 2: dot product sum and lit decision.
   logic               p2_vld_ff, p2_lit_ff, p2_lit_in;
   logic signed [34:0] p2_dot_ff, p2_dot_in;
   logic signed [16:0] p2_nz_ff, p2_sz_ff;

   // An element of a packed array reads as unsigned, so each product is
   // made signed again before it is extended.
   always_comb begin
      p2_dot_in = 35'($signed(p1_prod_ff[0])) + 35'($signed(p1_prod_ff[1]))
                  + 35'($signed(p1_prod_ff[2]));
      p2_lit_in = p1_ok_ff && !p2_dot_in[34] && (p2_dot_in != 35'd0);
   end

   // Stage 3: Lambert term in Q1.15.
   logic               p3_vld_ff, p3_lit_ff;
   logic [15:0]        p3_lam_ff, p3_lam_in;
   logic signed [16:0] p3_nz_ff, p3_sz_ff;
   logic [31:0]        p3_rnd;

   always_comb begin
      p3_rnd = p2_dot_ff[31:0] + 32'd16384;
      if (!p2_lit_ff) begin
         p3_lam_in = '0;
      end else if (p3_rnd[31:15] > 17'd32768) begin
         p3_lam_in = 16'd32768;
      end else begin
         p3_lam_in = p3_rnd[30:15];
      end
   end

   // Stage 4: lam * n.z.
   logic               p4_vld_ff, p4_lit_ff;
   logic [15:0]        p4_lam_ff;
   logic signed [33:0] p4_prod_ff, p4_prod_in;
   logic signed [16:0] p4_sz_ff;

   assign p4_prod_in = $signed({1'b0, p3_lam_ff}) * p3_nz_ff;

   // Stage 5: reflected z and specular base.
   logic               p5_vld_ff, p5_lit_ff;
   logic [15:0]        p5_lam_ff;
   logic [15:0]        p5_sp_ff, p5_sp_in;
   logic signed [35:0] p5_rz;
   logic [32:0]        p5_rnd;

   always_comb begin
      p5_rz  = {p4_prod_ff[33], p4_prod_ff, 1'b0} - {{4{p4_sz_ff[16]}}, p4_sz_ff, 15'd0};
      p5_rnd = p5_rz[32:0] + 33'd16384;
      if (p5_rz[35] || (p5_rz == 36'd0)) begin
         p5_sp_in = '0;
      end else if (p5_rnd[32:15] > 18'd32768) begin
         p5_sp_in = 16'd32768;
      end else begin
         p5_sp_in = p5_rnd[30:15];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_vld_ff <= 1'b0;
         p2_vld_ff <= 1'b0;
         p3_vld_ff <= 1'b0;
         p4_vld_ff <= 1'b0;
         p5_vld_ff <= 1'b0;
      end else if (adv) begin
         p1_vld_ff <= in_valid;
         p2_vld_ff <= p1_vld_ff;
         p3_vld_ff <= p2_vld_ff;
         p4_vld_ff <= p3_vld_ff;
         p5_vld_ff <= p4_vld_ff;
      end
      if (adv) begin
         p1_ok_ff   <= light.ok && norm.ok;
         p1_prod_ff <= p1_prod_in;
         p1_nz_ff   <= norm.z;
         p1_sz_ff   <= light.z;
         p2_lit_ff  <= p2_lit_in;
         p2_dot_ff  <= p2_dot_in;
         p2_nz_ff   <= p1_nz_ff;
         p2_sz_ff   <= p1_sz_ff;
         p3_lit_ff  <= p2_lit_ff;
         p3_lam_ff  <= p3_lam_in;
         p3_nz_ff   <= p2_nz_ff;
         p3_sz_ff   <= p2_sz_ff;
         p4_lit_ff  <= p3_lit_ff;
         p4_lam_ff  <= p3_lam_ff;
         p4_prod_ff <= p4_prod_in;
         p4_sz_ff   <= p3_sz_ff;
         p5_lit_ff  <= p4_lit_ff;
         p5_lam_ff  <= p4_lam_ff;
         p5_sp_ff   <= p5_sp_in;
      end
   end

   // Power stages: one exponent bit per stage, from the least significant.
   logic        pw_vld_ff  [0:PowSteps];
   logic        pw_lit_ff  [0:PowSteps];
   logic [15:0] pw_lam_ff  [0:PowSteps];
   logic [15:0] pw_acc_ff  [0:PowSteps];
   logic [15:0] pw_base_ff [0:PowSteps];
   logic [15:0] pw_acc_in  [0:PowSteps];
   logic [15:0] pw_base_in [0:PowSteps];

   assign pw_acc_in[0]  = 16'd32768;
   assign pw_base_in[0] = p5_sp_ff;

   for (genvar k = 0; k < PowSteps; k++) begin : g_pow
      assign pw_acc_in[k+1]  = cfg.shine[k] ? qmul(pw_acc_ff[k], pw_base_ff[k])
                                            : pw_acc_ff[k];
      assign pw_base_in[k+1] = qmul(pw_base_ff[k], pw_base_ff[k]);
   end

   for (genvar k = 0; k <= PowSteps; k++) begin : g_pow_reg
      always_ff @(posedge clock) begin
         if (reset) begin
            pw_vld_ff[k] <= 1'b0;
         end else if (adv) begin
            pw_vld_ff[k] <= (k == 0) ? p5_vld_ff : pw_vld_ff[(k == 0) ? 0 : k - 1];
         end
         if (adv) begin
            pw_lit_ff[k]  <= (k == 0) ? p5_lit_ff : pw_lit_ff[(k == 0) ? 0 : k - 1];
            pw_lam_ff[k]  <= (k == 0) ? p5_lam_ff : pw_lam_ff[(k == 0) ? 0 : k - 1];
            pw_acc_ff[k]  <= pw_acc_in[k];
            pw_base_ff[k] <= pw_base_in[k];
         end
      end
   end

   // Per-channel products, then sum, round and saturate.
   logic             ac_vld_ff;
   logic [2:0][30:0] ac_amb_ff, ac_amb_in;
   logic [2:0][31:0] ac_dif_ff, ac_dif_in;
   logic [2:0][31:0] ac_spc_ff, ac_spc_in;
   logic [15:0]      ac_lam, ac_pow;

   always_comb begin
      ac_lam = pw_lit_ff[PowSteps] ? pw_lam_ff[PowSteps] : 16'd0;
      ac_pow = pw_lit_ff[PowSteps] ? pw_acc_ff[PowSteps] : 16'd0;
      for (int c = 0; c < 3; c++) begin
         ac_amb_in[c] = {cfg.ambient[16*c +: 16], 15'd0};
         ac_dif_in[c] = ac_lam * cfg.diffuse[16*c +: 16];
         ac_spc_in[c] = ac_pow * cfg.specular[16*c +: 16];
      end
   end

   logic             out_vld_ff;
   logic [2:0][15:0] out_ch_ff, out_ch_in;
   logic [2:0][33:0] sum;

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         sum[c] = {3'd0, ac_amb_ff[c]} + {2'd0, ac_dif_ff[c]} + {2'd0, ac_spc_ff[c]}
                  + 34'd32768;
         out_ch_in[c] = (sum[c][33:32] != 2'd0) ? 16'hFFFF : sum[c][31:16];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ac_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         ac_vld_ff  <= pw_vld_ff[PowSteps];
         out_vld_ff <= ac_vld_ff;
      end
      if (adv) begin
         ac_amb_ff <= ac_amb_in;
         ac_dif_ff <= ac_dif_in;
         ac_spc_ff <= ac_spc_in;
         out_ch_ff <= out_ch_in;
      end
   end

   assign out_valid     = out_vld_ff;
   assign out_rgb.red   = out_ch_ff[2];
   assign out_rgb.green = out_ch_ff[1];
   assign out_rgb.blue  = out_ch_ff[0];

endmodule

### design/phong_fragment_lighting.sv
// ----------------------------------------------------------------------------
// phong_fragment_lighting
// Per-fragment ambient/diffuse/specular lighting of an eye-space normal.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake            Payload
//  req_chan  in         valid/ready          normal_x, normal_y, normal_z
//  rsp_chan  out        valid/ready          red, green, blue
//  csr_*     in         csr_wr_en            csr_index, csr_wdata
//
// One word enters per cycle while the output is not stalled. Each word passes
// 66 register stages, 50 in the normalizer (one for the squares, 32 for the
// 31-step square root, 17 for the 16-step divider) and 16 in shading. Synchronous
// reset empties the pipeline and loads the register defaults. The whole
// pipeline holds while a result waits on rsp_chan.
module phong_fragment_lighting (
   input  logic         clock,
   input  logic         reset,
   pfl_req_if.sink      req_chan,
   pfl_rsp_if.source    rsp_chan,
   input  logic         csr_wr_en,
   input  logic [2:0]   csr_index,
   input  logic [47:0]  csr_wdata
);
   import pfl_pkg::*;

   logic signed [15:0] light_x_ff, light_y_ff, light_z_ff;
   shade_cfg_type      cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         light_x_ff      <= 16'sd0;
         light_y_ff      <= 16'sd32767;
         light_z_ff      <= 16'sd0;
         cfg_ff.ambient  <= '0;
         cfg_ff.diffuse  <= '0;
         cfg_ff.specular <= '0;
         cfg_ff.shine    <= 8'd128;
      end else if (csr_wr_en) begin
         unique case (csr_idx_type'(csr_index))
            CSR_LIGHT_X:  light_x_ff      <= csr_wdata[15:0];
            CSR_LIGHT_Y:  light_y_ff      <= csr_wdata[15:0];
            CSR_LIGHT_Z:  light_z_ff      <= csr_wdata[15:0];
            CSR_AMBIENT:  cfg_ff.ambient  <= csr_wdata;
            CSR_DIFFUSE:  cfg_ff.diffuse  <= csr_wdata;
            CSR_SPECULAR: cfg_ff.specular <= csr_wdata;
            CSR_SHINE:    cfg_ff.shine    <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   logic     adv;
   logic     norm_valid;
   unit_type norm_unit, light_unit;
   rgb_type  rgb;
   logic     out_valid;

   assign adv            = !out_valid || rsp_chan.ready;
   assign req_chan.ready = adv;

   pfl_norm u_norm (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_chan.valid),
      .in_x      (req_chan.normal_x),
      .in_y      (req_chan.normal_y),
      .in_z      (req_chan.normal_z),
      .out_valid (norm_valid),
      .out_unit  (norm_unit)
   );

   // The light runs through a twin normalizer so it lines up with each word.
   pfl_norm u_light (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_chan.valid),
      .in_x      (light_x_ff),
      .in_y      (light_y_ff),
      .in_z      (light_z_ff),
      .out_valid (),
      .out_unit  (light_unit)
   );

   pfl_shade u_shade (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (norm_valid),
      .light     (light_unit),
      .norm      (norm_unit),
      .cfg       (cfg_ff),
      .out_valid (out_valid),
      .out_rgb   (rgb)
   );

   assign rsp_chan.valid = out_valid;
   assign rsp_chan.red   = rgb.red;
   assign rsp_chan.green = rgb.green;
   assign rsp_chan.blue  = rgb.blue;

endmodule

### design/pfl_checker.sv
// ----------------------------------------------------------------------------
// pfl_checker
// Port-level checks on the lighting block, bound to the top level.
// ----------------------------------------------------------------------------
module pfl_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_red,
   input logic [15:0] rsp_green,
   input logic [15:0] rsp_blue
);

   // A stalled result word holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_red) && $stable(rsp_green)
                                  && $stable(rsp_blue))
      else $error("stalled result word changed");

   // Reset empties the pipeline.
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // With no result waiting, the input side is open.
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input blocked with empty output");

   // A blocked output stalls the input side.
   a_ready_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("input taken while output stalled");

endmodule

bind phong_fragment_lighting pfl_checker u_pfl_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_red   (rsp_chan.red),
   .rsp_green (rsp_chan.green),
   .rsp_blue  (rsp_chan.blue)
);

### sim/tb_phong_fragment_lighting.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_phong_fragment_lighting
// Drives normal words through the lighting pipeline under several light and
// material settings and idle patterns, and checks every color word against a
// table value or a fixed-point shading predictor kept inside the testbench.
// ----------------------------------------------------------------------------
module tb_phong_fragment_lighting;
   import pfl_pkg::*;

   localparam int Latency    = 66;
   localparam int CycleLimit = 900000;

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic [2:0]  csr_index;
   logic [47:0] csr_wdata;

   pfl_req_if req_chan ();
   pfl_rsp_if rsp_chan ();

   phong_fragment_lighting u_top (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan.sink),
      .rsp_chan  (rsp_chan.source),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Shadow copy of the lighting registers.
   logic signed [15:0] lx, ly, lz;
   logic [47:0]        ka, kd, ks;
   logic [7:0]         shine;

   rgb_type color_queue[$];
   int      fail_count;
   int      cycle_count;
   int      send_idle_pct;
   int      recv_stall_pct;
   int      hold_cycles;

   typedef struct {
      logic signed [15:0] x, y, z;
      logic               known;
      rgb_type            color;
   } frag_row_type;

   frag_row_type frag_table[$];

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic logic [63:0] int_sqrt(input logic [63:0] v);
      logic [63:0] res, bitv, x;
      res  = 0;
      x    = v;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (x >= res + bitv) begin
            x   = x - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic logic make_unit(input logic signed [15:0] x, y, z,
                                      output longint u[3]);
      longint      c[3];
      logic [63:0] len2, root, mag, q;
      c[0] = x; c[1] = y; c[2] = z;
      len2 = 0;
      for (int i = 0; i < 3; i++) len2 += c[i] * c[i];
      if (len2 == 0) return 1'b0;
      root = int_sqrt(len2 << 30);
      if (root == 0) return 1'b0;
      for (int i = 0; i < 3; i++) begin
         mag  = (c[i] < 0) ? -c[i] : c[i];
         q    = (mag << 30) / root;
         u[i] = (c[i] < 0) ? -longint'(q) : longint'(q);
      end
      return 1'b1;
   endfunction

   function automatic logic [63:0] mul_q15(input logic [63:0] a, b);
      return (a * b + 64'd16384) >> 15;
   endfunction

   function automatic rgb_type shade_fragment(input logic signed [15:0] nx, ny, nz);
      longint      s[3], n[3], d, rz;
      logic [63:0] lam, pw, sp, base, acc, o;
      logic        lit;
      logic [15:0] ch[3];
      lam = 0; pw = 0; lit = 1'b0;
      if (make_unit(lx, ly, lz, s) && make_unit(nx, ny, nz, n)) begin
         d = s[0] * n[0] + s[1] * n[1] + s[2] * n[2];
         if (d > 0) begin
            lit = 1'b1;
            lam = (d + 16384) >> 15;
            if (lam > 32768) lam = 32768;
            rz = 2 * longint'(lam) * n[2] - s[2] * 32768;
            sp = 0;
            if (rz > 0) begin
               sp = (rz + 16384) >> 15;
               if (sp > 32768) sp = 32768;
            end
            pw   = 32768;
            base = sp;
            for (int k = 0; k < 8; k++) begin
               if (shine[k]) pw = mul_q15(pw, base);
               base = mul_q15(base, base);
            end
         end
      end
      for (int k = 0; k < 3; k++) begin
         acc = 64'(ka[47 - 16 * k -: 16]) << 15;
         if (lit) begin
            acc += lam * kd[47 - 16 * k -: 16];
            acc += pw * ks[47 - 16 * k -: 16];
         end
         o = (acc + 64'd32768) >> 16;
         if (o > 65535) o = 65535;
         ch[k] = o[15:0];
      end
      return '{red: ch[0], green: ch[1], blue: ch[2]};
   endfunction

   // Holds the write strobe; load_material drops it after the last register.
   task automatic write_reg(input csr_idx_type idx, input logic [47:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      case (idx)
         CSR_LIGHT_X:  lx    = val[15:0];
         CSR_LIGHT_Y:  ly    = val[15:0];
         CSR_LIGHT_Z:  lz    = val[15:0];
         CSR_AMBIENT:  ka    = val;
         CSR_DIFFUSE:  kd    = val;
         CSR_SPECULAR: ks    = val;
         CSR_SHINE:    shine = val[7:0];
         default: ;
      endcase
   endtask

   task automatic load_material(input logic signed [15:0] x, y, z,
                                input logic [47:0] a, dif, spec, input logic [7:0] e);
      write_reg(CSR_LIGHT_X, 48'(x));
      write_reg(CSR_LIGHT_Y, 48'(y));
      write_reg(CSR_LIGHT_Z, 48'(z));
      write_reg(CSR_AMBIENT, a);
      write_reg(CSR_DIFFUSE, dif);
      write_reg(CSR_SPECULAR, spec);
      write_reg(CSR_SHINE, 48'(e));
      csr_wr_en <= 1'b0;
   endtask

   // Offers one normal word, idling first at the current rate. Valid stays
   // high after an accept so that back-to-back words leave no gap.
   task automatic send_normal(input logic signed [15:0] x, y, z,
                              input logic known, input rgb_type color);
      rgb_type want_color;
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid    <= 1'b1;
      req_chan.normal_x <= x;
      req_chan.normal_y <= y;
      req_chan.normal_z <= z;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      want_color  = known ? color : shade_fragment(x, y, z);
      color_queue = {color_queue, want_color};
      @(negedge clock);
   endtask

   function automatic logic signed [15:0] rand_comp();
      case ($urandom_range(5))
         0:       return 16'sh7FFF;
         1:       return 16'sh8000;
         2:       return 16'($signed($urandom_range(8)) - 4);
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic drain();
      req_chan.valid <= 1'b0;
      while (color_queue.size() != 0) @(negedge clock);
      repeat (Latency + 8) @(negedge clock);
   endtask

   task automatic random_phase(input int count, input int idle, input int stall);
      send_idle_pct  = idle;
      recv_stall_pct = stall;
      for (int i = 0; i < count; i++)
         send_normal(rand_comp(), rand_comp(), rand_comp(), 1'b0, '0);
      drain();
   endtask

   // Receiver: stalls at random, or for a long stretch when asked.
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (color_queue.size() == 0) begin
            $display("%0t: unexpected color word %h %h %h", $time,
                     rsp_chan.red, rsp_chan.green, rsp_chan.blue);
            fail_count <= fail_count + 1;
         end else begin
            rgb_type want;
            want = color_queue.pop_front();
            if (want.red !== rsp_chan.red || want.green !== rsp_chan.green ||
                want.blue !== rsp_chan.blue) begin
               $display("%0t: color mismatch expected %h %h %h actual %h %h %h", $time,
                        want.red, want.green, want.blue,
                        rsp_chan.red, rsp_chan.green, rsp_chan.blue);
               fail_count <= fail_count + 1;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (cycle_count > CycleLimit) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      fail_count     = 0;
      cycle_count    = 0;
      hold_cycles    = 0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      reset          = 1'b1;
      csr_wr_en      = 1'b0;
      csr_index      = CSR_LIGHT_X;
      csr_wdata      = '0;
      req_chan.valid    = 1'b0;
      req_chan.normal_x = '0;
      req_chan.normal_y = '0;
      req_chan.normal_z = '0;
      rsp_chan.ready    = 1'b1;
      lx = 0; ly = 16'sd32767; lz = 0;
      ka = '0; kd = '0; ks = '0; shine = 8'd128;
      repeat (11) @(negedge clock);
      reset = 1'b0;

      // With reset materials every color is black.
      send_normal(16'sd0, 16'sd100, 16'sd0, 1'b1, '0);
      send_normal(16'sd0, 16'sd0, 16'sd0, 1'b1, '0);
      drain();

      // Unlit normals give ambient only; full-scale diffuse and specular: saturation and extremes.
      load_material(16'sd0, 16'sd0, 16'sd32767, 48'h4000_2000_0000,
                    48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 8'd0);
      frag_table = '{
         '{16'sd0, 16'sd0, 16'sd0, 1'b1, '{16'h2000, 16'h1000, 16'h0000}},
         '{16'sd0, 16'sd0, -16'sd5, 1'b1, '{16'h2000, 16'h1000, 16'h0000}},
         '{16'sd0, 16'sd0, 16'sd1, 1'b0, '0},
         '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b0, '0},
         '{16'sh8000, 16'sh8000, 16'sh8000, 1'b0, '0},
         '{16'sh8000, 16'sd0, 16'sd0, 1'b0, '0},
         '{16'sd3, 16'sd0, 16'sd4, 1'b0, '0},
         '{16'sd1, 16'sd1, 16'sd1, 1'b0, '0}
      };
      foreach (frag_table[i])
         send_normal(frag_table[i].x, frag_table[i].y, frag_table[i].z,
                     frag_table[i].known, frag_table[i].color);
      drain();

      // Zero-length light: ambient only.
      load_material(16'sd0, 16'sd0, 16'sd0, 48'h1234_5678_0ABC,
                    48'h8000_8000_8000, 48'h8000_8000_8000, 8'd255);
      send_normal(16'sd0, 16'sd0, 16'sd7, 1'b1, '{16'h091A, 16'h2B3C, 16'h055E});
      send_normal(16'sh8000, 16'sd9, 16'sh7FFF, 1'b1, '{16'h091A, 16'h2B3C, 16'h055E});
      drain();

      load_material(16'sd1000, -16'sd2000, 16'sd3000, 48'h0800_0400_0200,
                    48'h6000_5000_4000, 48'h8000_7000_FFFF, 8'd1);
      random_phase(250, 0, 0);

      load_material(16'sh8000, 16'sh8000, 16'sh7FFF, 48'h0000_0000_0000,
                    48'h8000_8000_8000, 48'h8000_8000_8000, 8'd255);
      random_phase(250, 78, 0);

      load_material(16'($urandom), 16'($urandom), 16'($urandom), 48'($urandom),
                    {16'($urandom), 32'($urandom)}, {16'($urandom), 32'($urandom)},
                    8'($urandom));
      random_phase(250, 0, 78);

      load_material(-16'sd1, 16'sd0, 16'sd1, 48'hFFFF_FFFF_FFFF,
                    48'h0000_0000_0000, 48'h7FFF_0001_4000, 8'd16);
      random_phase(250, 36, 36);

      // Long receiver hold while the sender keeps offering.
      load_material(16'sd0, 16'sd0, 16'sd1, 48'h0400_0400_0400,
                    48'h7000_6000_5000, 48'h8000_8000_8000, 8'd5);
      hold_cycles = 300;
      random_phase(300, 0, 0);

      for (int p = 0; p < 4; p++) begin
         load_material(16'($urandom), 16'($urandom), 16'($urandom),
                       {16'($urandom), 32'($urandom)}, {16'($urandom), 32'($urandom)},
                       {16'($urandom), 32'($urandom)}, 8'($urandom_range(40)));
         random_phase(85, (p % 2) * 78, (p / 2) * 78);
      end

      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule
